/* hw/rtl/u8t_pkg.sv */
// ----------------------------------------------------------------------------
// u8t_pkg: shared types and constants for the 8N1 UART transceiver
// Register indexes, reset values, default sizes and the status structs
// that pass between the transmitter, receiver and top level.
// ----------------------------------------------------------------------------
package u8t_pkg;

  // default sizes
  localparam int TIMER_BITS_DEF = 16;
  localparam int DATA_BITS_DEF  = 8;

  // configuration port
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BIT_PERIOD = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_RX_ENABLE  = CFG_INDEX_BITS'(1);

  // register reset values and limits
  localparam logic [15:0] BIT_PERIOD_RESET = 16'd625;
  localparam logic [15:0] BIT_PERIOD_MIN   = 16'd16;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_out_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rx_out_t;

endpackage

/* hw/rtl/u8t_tx.sv */
// ----------------------------------------------------------------------------
// u8t_tx: 8N1 transmitter, one bit-timer tick per step
// Takes a byte while idle, then sends start, data LSB first and stop.
// ----------------------------------------------------------------------------
module u8t_tx #(
  parameter int TIMER_BITS = u8t_pkg::TIMER_BITS_DEF,
  parameter int DATA_BITS  = u8t_pkg::DATA_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [TIMER_BITS:0]   period,
  input  logic                  start,
  input  logic [7:0]            data,
  output u8t_pkg::tx_out_t      status
);

  localparam int IW = $clog2(DATA_BITS + 2);

  logic                  active;
  logic [DATA_BITS-1:0]  shift;
  logic [IW-1:0]         bit_index;
  logic [TIMER_BITS-1:0] timer;

  logic                  active_next;
  logic [DATA_BITS-1:0]  shift_next;
  logic [IW-1:0]         bit_index_next;
  logic [TIMER_BITS-1:0] timer_next;

  logic                  run;
  logic [DATA_BITS-1:0]  shift_cur;
  logic [IW-1:0]         index_cur;
  logic [TIMER_BITS:0]   timer_inc;
  logic [DATA_BITS-1:0]  data_ext;

  generate
    if (DATA_BITS >= 8) begin : g_wide
      assign data_ext = DATA_BITS'(data);
    end else begin : g_narrow
      assign data_ext = data[DATA_BITS-1:0];
    end
  endgenerate

  always_comb begin
    // a start request taken while idle drives the start bit on this tick
    run       = active | start;
    shift_cur = active ? shift : data_ext;
    index_cur = active ? bit_index : '0;
    timer_inc = active ? ({1'b0, timer} + (TIMER_BITS+1)'(1)) : (TIMER_BITS+1)'(1);

    active_next    = active;
    shift_next     = shift;
    bit_index_next = bit_index;
    timer_next     = timer;

    status.busy = run;
    status.line = 1'b1;

    if (run) begin
      if (index_cur == '0) begin
        status.line = 1'b0;
      end else if (index_cur <= IW'(DATA_BITS)) begin
        status.line = shift_cur[0];
      end

      active_next    = 1'b1;
      shift_next     = shift_cur;
      bit_index_next = index_cur;
      if (timer_inc >= period) begin
        timer_next = '0;
        if (index_cur >= IW'(DATA_BITS + 1)) begin
          active_next    = 1'b0;
          bit_index_next = '0;
        end else begin
          if (index_cur != '0) begin
            shift_next = shift_cur >> 1;
          end
          bit_index_next = index_cur + IW'(1);
        end
      end else begin
        timer_next = timer_inc[TIMER_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      shift     <= '0;
      bit_index <= '0;
      timer     <= '0;
    end else if (step) begin
      active    <= active_next;
      shift     <= shift_next;
      bit_index <= bit_index_next;
      timer     <= timer_next;
    end
  end

endmodule

/* hw/rtl/u8t_rx.sv */
// ----------------------------------------------------------------------------
// u8t_rx: 8N1 receiver, one bit-timer tick per step
// Arms on a falling edge, samples mid-bit and reports at mid stop bit.
// ----------------------------------------------------------------------------
module u8t_rx #(
  parameter int TIMER_BITS = u8t_pkg::TIMER_BITS_DEF,
  parameter int DATA_BITS  = u8t_pkg::DATA_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [TIMER_BITS:0]   period,
  input  logic                  enable,
  input  logic                  line,
  output u8t_pkg::rx_out_t      status
);

  localparam int IW = $clog2(DATA_BITS + 2);

  logic                  active;
  logic [DATA_BITS-1:0]  shift;
  logic [IW-1:0]         bit_index;
  logic [TIMER_BITS-1:0] timer;
  logic                  line_prev;

  logic                  active_next;
  logic [DATA_BITS-1:0]  shift_next;
  logic [IW-1:0]         bit_index_next;
  logic [TIMER_BITS-1:0] timer_next;

  logic [TIMER_BITS:0]   target;
  logic [TIMER_BITS:0]   timer_inc;
  logic [7:0]            shift_byte;

  generate
    if (DATA_BITS >= 8) begin : g_wide
      assign shift_byte = shift[7:0];
    end else begin : g_narrow
      assign shift_byte = 8'(shift);
    end
  endgenerate

  always_comb begin
    // half a period to the middle of the start bit, a full one after that
    target    = (bit_index == '0) ? (period >> 1) : period;
    timer_inc = {1'b0, timer} + (TIMER_BITS+1)'(1);

    active_next    = active;
    shift_next     = shift;
    bit_index_next = bit_index;
    timer_next     = timer;

    status.valid = 1'b0;
    status.data  = '0;

    priority if (!enable) begin
      active_next = 1'b0;
    end else if (active) begin
      if (timer_inc >= target) begin
        timer_next = '0;
        if (bit_index == '0) begin
          bit_index_next = IW'(1);
        end else if (bit_index <= IW'(DATA_BITS)) begin
          for (int i = 0; i < DATA_BITS; i++) begin
            if (line && (bit_index == IW'(i + 1))) begin
              shift_next[i] = 1'b1;
            end
          end
          bit_index_next = bit_index + IW'(1);
        end else begin
          // middle of the stop bit: hand the byte over and re-arm
          status.valid   = 1'b1;
          status.data    = shift_byte;
          active_next    = 1'b0;
          bit_index_next = '0;
        end
      end else begin
        timer_next = timer_inc[TIMER_BITS-1:0];
      end
    end else if (line_prev && !line) begin
      active_next    = 1'b1;
      timer_next     = '0;
      bit_index_next = '0;
      shift_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      shift     <= '0;
      bit_index <= '0;
      timer     <= '0;
      line_prev <= 1'b1;
    end else if (step) begin
      active    <= active_next;
      shift     <= shift_next;
      bit_index <= bit_index_next;
      timer     <= timer_next;
      line_prev <= line;
    end
  end

endmodule

/* hw/rtl/uart_8n1_transceiver.sv */
// ----------------------------------------------------------------------------
// uart_8n1_transceiver: 8N1 UART transmitter and receiver, one tick per beat
// Each input beat advances both bit timers by one tick and yields one
// output beat with the transmit line, busy flag and any received byte.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | sink      | in_valid / in_stall   | tx_start, tx_byte, rx_line
//   out     | source    | out_valid / out_stall | tx_line, tx_busy, rx_valid,
//           |           |                       | rx_byte
//   cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat per cycle while not stalled: an input beat updates the timer state
// and lands in the output register on the same edge.
// The output register is the only buffer; in_stall rises only while it is
// full and out_stall holds it, so a beat is taken every cycle otherwise.
// Synchronous active-high reset sets the control state, not the payload;
// bit_period comes up at 625, the receiver disabled. cfg_ready is always high.
// ----------------------------------------------------------------------------
module uart_8n1_transceiver #(
  parameter int TIMER_BITS = u8t_pkg::TIMER_BITS_DEF,
  parameter int DATA_BITS  = u8t_pkg::DATA_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               tx_start,
  input  logic [7:0]                         tx_byte,
  input  logic                               rx_line,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               tx_line,
  output logic                               tx_busy,
  output logic                               rx_valid,
  output logic [7:0]                         rx_byte,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [u8t_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [u8t_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // wide enough for both the 16-bit register and the 2^TIMER_BITS cap
  localparam int WW = (TIMER_BITS + 1 > 16) ? TIMER_BITS + 1 : 16;

  logic [15:0]         bit_period;
  logic                rx_enable;

  logic                step;
  logic [WW-1:0]       period_wide;
  logic [WW-1:0]       period_cap;
  logic [WW-1:0]       period_clamp;
  logic [TIMER_BITS:0] period;

  u8t_pkg::tx_out_t    tx_status;
  u8t_pkg::rx_out_t    rx_status;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= u8t_pkg::BIT_PERIOD_RESET;
      rx_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      // unknown indexes drop silently
      if (cfg_index == u8t_pkg::REG_BIT_PERIOD) begin
        bit_period <= cfg_data[15:0];
      end else if (cfg_index == u8t_pkg::REG_RX_ENABLE) begin
        rx_enable <= cfg_data[0];
      end
    end
  end

  // clamp the period into [16, 2^TIMER_BITS]
  always_comb begin
    period_wide = WW'(bit_period);
    period_cap  = WW'(1) << TIMER_BITS;
    priority if (bit_period < u8t_pkg::BIT_PERIOD_MIN) begin
      period_clamp = WW'(u8t_pkg::BIT_PERIOD_MIN);
    end else if (period_wide > period_cap) begin
      period_clamp = period_cap;
    end else begin
      period_clamp = period_wide;
    end
  end

  assign period = period_clamp[TIMER_BITS:0];

  // -------------------------------------------------------------- handshake
  // advance a tick on each input beat while the output register is free or draining
  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  u8t_tx #(
    .TIMER_BITS (TIMER_BITS),
    .DATA_BITS  (DATA_BITS)
  ) u_tx (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .period (period),
    .start  (tx_start),
    .data   (tx_byte),
    .status (tx_status)
  );

  u8t_rx #(
    .TIMER_BITS (TIMER_BITS),
    .DATA_BITS  (DATA_BITS)
  ) u_rx (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .period (period),
    .enable (rx_enable),
    .line   (rx_line),
    .status (rx_status)
  );

  // --------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload: hold while stalled, load on every taken beat
  always_ff @(posedge clk) begin
    if (step) begin
      tx_line  <= tx_status.line;
      tx_busy  <= tx_status.busy;
      rx_valid <= rx_status.valid;
      rx_byte  <= rx_status.data;
    end
  end

  // ------------------------------------------------------------- assertions
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted beat did not reach the output register");

  a_idle_line_high: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tx_busy) |-> tx_line)
    else $error("tx line low while transmitter idle");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rx_valid) |-> (rx_byte == 8'd0))
    else $error("rx_byte nonzero without rx_valid");

  a_rx_off: assert property (@(posedge clk) disable iff (rst)
    (step && !rx_enable) |=> !rx_valid)
    else $error("byte received while receiver disabled");

endmodule
